@@ hdl/bvle_pkg.sv @@
// bvle_pkg: shared types and constants of the bounded value list engine
// command codes, status codes, state encoding and controller/datapath bundles
// depends on nothing
package bvle_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int FUNC_W         = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int CNT_OUT_W      = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_SEARCH     = 3'd2,
        FN_REMOVE     = 3'd3,
        FN_DUMP_FWD   = 3'd4,
        FN_DUMP_BWD   = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PF_RD,
        S_PF_WR,
        S_PF_HEAD,
        S_SC_RD,
        S_SC_CMP,
        S_RM_RD,
        S_RM_WR,
        S_DP_RD,
        S_DP_OUT
    } t_state;

    typedef enum logic [1:0] {
        WA_ZERO,
        WA_COUNT,
        WA_PTR_UP,
        WA_PTR_DN
    } t_waddr;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_CNT_M1,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    wr_en;
        t_waddr  wa;
        t_ptr_op ptr_op;
        t_cnt_op cnt_op;
        logic    emit;
        logic    emit_entry;
        logic    found;
        t_status status;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ptr_zero;
        logic ptr_last;
        logic ptr_end;
        logic match;
    } t_dp_stat;

endpackage

@@ hdl/bvle_dp.sv @@
// bvle_dp: datapath of the list engine
// entry memory, count, walk pointer, read register and result registers
// depends on bvle_pkg
module bvle_dp #(
    parameter int LIST_DEPTH = bvle_pkg::DEF_LIST_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [bvle_pkg::VALUE_W-1:0] i_value,
    input  bvle_pkg::t_dp_cmd                   i_cmd,
    output bvle_pkg::t_dp_stat                  o_stat,
    output logic                                o_strobe,
    output logic signed [bvle_pkg::VALUE_W-1:0] o_entry_value,
    output logic                                o_found,
    output logic [bvle_pkg::STATUS_W-1:0]       o_status,
    output logic [bvle_pkg::CNT_OUT_W-1:0]      o_entry_count,
    output logic                                o_last
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [bvle_pkg::VALUE_W-1:0] mem [LIST_DEPTH];

    logic [bvle_pkg::VALUE_W-1:0]   r_value;
    logic [bvle_pkg::VALUE_W-1:0]   r_rdata;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    logic [CW-1:0]                  r_ptr;
    logic [CW-1:0]                  n_ptr;
    logic [IW-1:0]                  waddr;
    logic [bvle_pkg::VALUE_W-1:0]   wdata;
    logic                           r_strobe;
    logic [bvle_pkg::VALUE_W-1:0]   r_entry;
    logic                           r_found;
    logic [bvle_pkg::STATUS_W-1:0]  r_status;
    logic [bvle_pkg::CNT_OUT_W-1:0] r_ocount;
    logic                           r_last;

    always_comb begin
        case (i_cmd.wa)
            bvle_pkg::WA_ZERO:   waddr = '0;
            bvle_pkg::WA_COUNT:  waddr = r_count[IW-1:0];
            bvle_pkg::WA_PTR_UP: waddr = IW'(r_ptr + CW'(1));
            bvle_pkg::WA_PTR_DN: waddr = IW'(r_ptr - CW'(1));
            default:             waddr = '0;
        endcase
    end

    assign wdata = (i_cmd.wa == bvle_pkg::WA_PTR_UP || i_cmd.wa == bvle_pkg::WA_PTR_DN)
                 ? r_rdata : r_value;

    always_comb begin
        case (i_cmd.ptr_op)
            bvle_pkg::PTR_HOLD:   n_ptr = r_ptr;
            bvle_pkg::PTR_ZERO:   n_ptr = '0;
            bvle_pkg::PTR_CNT_M1: n_ptr = r_count - CW'(1);
            bvle_pkg::PTR_INC:    n_ptr = r_ptr + CW'(1);
            bvle_pkg::PTR_DEC:    n_ptr = r_ptr - CW'(1);
            default:              n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            bvle_pkg::CNT_HOLD: n_count = r_count;
            bvle_pkg::CNT_INC:  n_count = r_count + CW'(1);
            bvle_pkg::CNT_DEC:  n_count = r_count - CW'(1);
            default:            n_count = r_count;
        endcase
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.emit) begin
            r_entry  <= i_cmd.emit_entry ? r_rdata : '0;
            r_found  <= i_cmd.found;
            r_status <= i_cmd.status;
            r_ocount <= bvle_pkg::CNT_OUT_W'(n_count);
            r_last   <= i_cmd.last;
        end
    end

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_full = (r_count == CW'(LIST_DEPTH));
    assign o_stat.ptr_zero = (r_ptr == '0);
    assign o_stat.ptr_last = (r_ptr == r_count - CW'(1));
    assign o_stat.ptr_end  = (r_ptr == r_count);
    assign o_stat.match    = (r_rdata == r_value);

    assign o_strobe      = r_strobe;
    assign o_entry_value = r_entry;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = r_ocount;
    assign o_last        = r_last;

endmodule

@@ hdl/bvle_ctrl.sv @@
// bvle_ctrl: command sequencer of the list engine
// walks the datapath through shifts, scans and dumps
// depends on bvle_pkg
module bvle_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [bvle_pkg::FUNC_W-1:0]       i_func,
    input  bvle_pkg::t_dp_stat                i_stat,
    output logic                              busy,
    output bvle_pkg::t_dp_cmd                 o_cmd
);

    bvle_pkg::t_state             r_state;
    bvle_pkg::t_state             n_state;
    logic [bvle_pkg::FUNC_W-1:0]  r_func;
    logic                         is_remove;
    logic                         is_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bvle_pkg::S_IDLE && start) begin
            r_func <= i_func;
        end
    end

    assign is_remove = (r_func == bvle_pkg::FN_REMOVE);
    assign is_fwd    = (r_func == bvle_pkg::FN_DUMP_FWD);
    assign busy      = (r_state != bvle_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = bvle_pkg::ST_OK;
        case (r_state)
            bvle_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = bvle_pkg::S_EXEC;
                end
            end
            bvle_pkg::S_EXEC: begin
                case (r_func)
                    bvle_pkg::FN_PUSH_FRONT, bvle_pkg::FN_PUSH_BACK: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = bvle_pkg::ST_FULL;
                            o_cmd.last   = 1'b1;
                            n_state      = bvle_pkg::S_IDLE;
                        end else if (r_func == bvle_pkg::FN_PUSH_BACK || i_stat.cnt_zero) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wa     = (r_func == bvle_pkg::FN_PUSH_BACK)
                                         ? bvle_pkg::WA_COUNT : bvle_pkg::WA_ZERO;
                            o_cmd.cnt_op = bvle_pkg::CNT_INC;
                            o_cmd.emit   = 1'b1;
                            o_cmd.last   = 1'b1;
                            n_state      = bvle_pkg::S_IDLE;
                        end else begin
                            o_cmd.ptr_op = bvle_pkg::PTR_CNT_M1;
                            n_state      = bvle_pkg::S_PF_RD;
                        end
                    end
                    bvle_pkg::FN_SEARCH, bvle_pkg::FN_REMOVE: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = is_remove ? bvle_pkg::ST_ABSENT : bvle_pkg::ST_OK;
                            o_cmd.last   = 1'b1;
                            n_state      = bvle_pkg::S_IDLE;
                        end else begin
                            o_cmd.ptr_op = bvle_pkg::PTR_ZERO;
                            n_state      = bvle_pkg::S_SC_RD;
                        end
                    end
                    bvle_pkg::FN_DUMP_FWD, bvle_pkg::FN_DUMP_BWD: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = bvle_pkg::ST_EMPTY;
                            o_cmd.last   = 1'b1;
                            n_state      = bvle_pkg::S_IDLE;
                        end else begin
                            o_cmd.ptr_op = is_fwd ? bvle_pkg::PTR_ZERO : bvle_pkg::PTR_CNT_M1;
                            n_state      = bvle_pkg::S_DP_RD;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state    = bvle_pkg::S_IDLE;
                    end
                endcase
            end
            bvle_pkg::S_PF_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bvle_pkg::S_PF_WR;
            end
            // move entry at ptr one place toward the back
            bvle_pkg::S_PF_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wa    = bvle_pkg::WA_PTR_UP;
                if (i_stat.ptr_zero) begin
                    n_state = bvle_pkg::S_PF_HEAD;
                end else begin
                    o_cmd.ptr_op = bvle_pkg::PTR_DEC;
                    n_state      = bvle_pkg::S_PF_RD;
                end
            end
            bvle_pkg::S_PF_HEAD: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa     = bvle_pkg::WA_ZERO;
                o_cmd.cnt_op = bvle_pkg::CNT_INC;
                o_cmd.emit   = 1'b1;
                o_cmd.last   = 1'b1;
                n_state      = bvle_pkg::S_IDLE;
            end
            bvle_pkg::S_SC_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bvle_pkg::S_SC_CMP;
            end
            bvle_pkg::S_SC_CMP: begin
                if (i_stat.match) begin
                    if (is_remove) begin
                        o_cmd.ptr_op = bvle_pkg::PTR_INC;
                        n_state      = bvle_pkg::S_RM_RD;
                    end else begin
                        o_cmd.emit  = 1'b1;
                        o_cmd.found = 1'b1;
                        o_cmd.last  = 1'b1;
                        n_state     = bvle_pkg::S_IDLE;
                    end
                end else if (i_stat.ptr_last) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = is_remove ? bvle_pkg::ST_ABSENT : bvle_pkg::ST_OK;
                    o_cmd.last   = 1'b1;
                    n_state      = bvle_pkg::S_IDLE;
                end else begin
                    o_cmd.ptr_op = bvle_pkg::PTR_INC;
                    n_state      = bvle_pkg::S_SC_RD;
                end
            end
            bvle_pkg::S_RM_RD: begin
                if (i_stat.ptr_end) begin
                    o_cmd.cnt_op = bvle_pkg::CNT_DEC;
                    o_cmd.emit   = 1'b1;
                    o_cmd.found  = 1'b1;
                    o_cmd.last   = 1'b1;
                    n_state      = bvle_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = bvle_pkg::S_RM_WR;
                end
            end
            // move entry at ptr one place toward the front
            bvle_pkg::S_RM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wa     = bvle_pkg::WA_PTR_DN;
                o_cmd.ptr_op = bvle_pkg::PTR_INC;
                n_state      = bvle_pkg::S_RM_RD;
            end
            bvle_pkg::S_DP_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = bvle_pkg::S_DP_OUT;
            end
            bvle_pkg::S_DP_OUT: begin
                o_cmd.emit       = 1'b1;
                o_cmd.emit_entry = 1'b1;
                o_cmd.last       = is_fwd ? i_stat.ptr_last : i_stat.ptr_zero;
                if (o_cmd.last) begin
                    n_state = bvle_pkg::S_IDLE;
                end else begin
                    o_cmd.ptr_op = is_fwd ? bvle_pkg::PTR_INC : bvle_pkg::PTR_DEC;
                    n_state      = bvle_pkg::S_DP_RD;
                end
            end
            default: begin
                n_state = bvle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bounded_value_list_engine_unit.sv @@
// bounded_value_list_engine_unit: top level of the list engine
// ordered list of signed 32-bit values with push, search, remove and dump
// depends on bvle_pkg, bvle_ctrl, bvle_dp
//
// Command channel: drive i_func and i_value with start; a command is taken at
// a clock edge where start is high and busy is low. busy stays high until the
// last result beat of the command has been issued.
// Result channel: each result beat is on the o_ ports for one cycle, marked by
// o_strobe, with o_last on the final beat of a command. The receiver cannot
// stall; every beat must be taken in the cycle it is shown.
// Steps of each command, n = entries held before the command; the edge that
// takes the last beat can also take the next command:
//   push back, full push, unused codes, empty search/remove/dump: one beat
//   push front onto n > 0 entries: a read and a write per entry, then head write
//   search, or remove of an absent value: a read and a compare per entry, up to n
//   remove at position p: scan to p, then compaction of each later entry
//   dump: a read and then a beat for each of the n entries
// The walk reads and writes the entry memory in separate steps; one command is
// in flight at a time.
// Reset (synchronous, active low) empties the list and clears the strobe; the
// entry memory itself is not cleared, as only held entries are ever read.
module bounded_value_list_engine_unit #(
    parameter int LIST_DEPTH = bvle_pkg::DEF_LIST_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bvle_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [bvle_pkg::VALUE_W-1:0] i_value,
    output logic                                o_strobe,
    output logic signed [bvle_pkg::VALUE_W-1:0] o_entry_value,
    output logic                                o_found,
    output logic [bvle_pkg::STATUS_W-1:0]       o_status,
    output logic [bvle_pkg::CNT_OUT_W-1:0]      o_entry_count,
    output logic                                o_last
);

    bvle_pkg::t_dp_cmd  dp_cmd;
    bvle_pkg::t_dp_stat dp_stat;

    bvle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    bvle_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_strobe      (o_strobe),
        .o_entry_value (o_entry_value),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    a_beat_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a command in progress");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (LIST_DEPTH > 31 || o_entry_count <= LIST_DEPTH))
        else $error("entry count above list depth");

    a_empty_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == bvle_pkg::ST_EMPTY) |-> (o_entry_count == '0 && o_last))
        else $error("empty dump beat with entries or without last");
`endif

endmodule

@@ dv/bvle_list_checker.sv @@
`timescale 1ns / 1ps
// bvle_list_checker: watches the command and result channels of the list engine,
// keeps its own copy of the list, predicts every result beat and compares them
// depends on bvle_pkg
module bvle_list_checker
    import bvle_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_strobe,
    input  logic signed [VALUE_W-1:0]  i_entry_value,
    input  logic                       i_found,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic [CNT_OUT_W-1:0]       i_entry_count,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_beats_pending
);

    typedef struct {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      found;
        t_status                   status;
        logic [CNT_OUT_W-1:0]      entry_count;
        logic                      last;
    } list_beat_t;

    logic signed [VALUE_W-1:0] held_entries[$];
    list_beat_t                expected_beats[$];
    int                        mismatches = 0;

    assign o_fail_count    = mismatches;
    assign o_beats_pending = expected_beats.size();

    task automatic report_mismatch(input string what);
        if (mismatches < 200) begin
            $display("%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic list_beat_t make_beat(input logic signed [VALUE_W-1:0] entry,
                                             input logic hit, input t_status st,
                                             input logic final_beat);
        list_beat_t b;
        b.entry_value = entry;
        b.found       = hit;
        b.status      = st;
        b.entry_count = CNT_OUT_W'(held_entries.size());
        b.last        = final_beat;
        return b;
    endfunction

    task automatic predict_command(input logic [FUNC_W-1:0] code,
                                   input logic signed [VALUE_W-1:0] value);
        int hit;
        int n;
        hit = -1;
        foreach (held_entries[i]) begin
            if (hit < 0 && held_entries[i] == value) begin
                hit = i;
            end
        end
        case (code)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (held_entries.size() >= LIST_DEPTH) begin
                    expected_beats.push_back(make_beat('0, 1'b0, ST_FULL, 1'b1));
                end else begin
                    if (code == FN_PUSH_FRONT) begin
                        held_entries.push_front(value);
                    end else begin
                        held_entries.push_back(value);
                    end
                    expected_beats.push_back(make_beat('0, 1'b0, ST_OK, 1'b1));
                end
            end
            FN_SEARCH: begin
                expected_beats.push_back(make_beat('0, hit >= 0, ST_OK, 1'b1));
            end
            FN_REMOVE: begin
                if (hit < 0) begin
                    expected_beats.push_back(make_beat('0, 1'b0, ST_ABSENT, 1'b1));
                end else begin
                    held_entries.delete(hit);
                    expected_beats.push_back(make_beat('0, 1'b1, ST_OK, 1'b1));
                end
            end
            FN_DUMP_FWD, FN_DUMP_BWD: begin
                n = held_entries.size();
                if (n == 0) begin
                    expected_beats.push_back(make_beat('0, 1'b0, ST_EMPTY, 1'b1));
                end else begin
                    for (int k = 0; k < n; k++) begin
                        expected_beats.push_back(make_beat(
                            held_entries[(code == FN_DUMP_FWD) ? k : n - 1 - k],
                            1'b0, ST_OK, k == n - 1));
                    end
                end
            end
            default: begin
                expected_beats.push_back(make_beat('0, 1'b0, ST_OK, 1'b1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin : beat_check
        list_beat_t want;
        if (!i_rst_n) begin
            held_entries.delete();
            expected_beats.delete();
        end else begin
            if (i_start && !i_busy) begin
                predict_command(i_func, i_value);
            end
            if (i_strobe) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, value %0d",
                                              i_entry_value));
                end else begin
                    want = expected_beats.pop_front();
                    if (i_entry_value !== want.entry_value) begin
                        report_mismatch($sformatf("entry_value %0d, expected %0d",
                                                  i_entry_value, want.entry_value));
                    end
                    if (i_found !== want.found) begin
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  i_found, want.found));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_entry_count !== want.entry_count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  i_entry_count, want.entry_count));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  i_last, want.last));
                    end
                end
            end
        end
    end

endmodule

@@ dv/bounded_value_list_engine_unit_test.sv @@
`timescale 1ns / 1ps
// bounded_value_list_engine_unit_test: top of the list engine testbench, drives
// directed and random commands with sender gaps and gives the verdict
// depends on bvle_pkg, bounded_value_list_engine_unit, bvle_list_checker
module bounded_value_list_engine_unit_test;
    import bvle_pkg::*;

    localparam int                LIST_DEPTH  = DEF_LIST_DEPTH;
    localparam logic [FUNC_W-1:0] FN_SPARE_A  = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B  = 3'd7;
    localparam int                TAIL_CYCLES = 2 * LIST_DEPTH + 10;
    localparam int                PHASE_CMDS  = 160;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [FUNC_W-1:0]          i_func;
    logic signed [VALUE_W-1:0]  i_value;
    logic                       o_strobe;
    logic signed [VALUE_W-1:0]  o_entry_value;
    logic                       o_found;
    logic [STATUS_W-1:0]        o_status;
    logic [CNT_OUT_W-1:0]       o_entry_count;
    logic                       o_last;
    int                         fail_count;
    int                         beats_pending;
    int                         sender_idle_pct;
    logic                       grow_list;
    logic signed [VALUE_W-1:0]  value_pool[8];

    bounded_value_list_engine_unit #(.LIST_DEPTH(LIST_DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_value(i_value), .o_strobe(o_strobe),
        .o_entry_value(o_entry_value), .o_found(o_found), .o_status(o_status),
        .o_entry_count(o_entry_count), .o_last(o_last)
    );

    bvle_list_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_value(i_value), .i_strobe(o_strobe),
        .i_entry_value(o_entry_value), .i_found(o_found), .i_status(o_status),
        .i_entry_count(o_entry_count), .i_last(o_last),
        .o_fail_count(fail_count), .o_beats_pending(beats_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("bounded_value_list_engine_unit verification failed");
        $finish;
    end

    task automatic issue_command(input logic [FUNC_W-1:0] code,
                                 input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= code;
        i_value <= value;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (beats_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return value_pool[$urandom_range(7)];
        end else if (r < 68) begin
            case ($urandom_range(3))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_code();
        int push_pct;
        int r;
        int s;
        push_pct = grow_list ? 65 : 25;
        r = $urandom_range(99);
        if (r < push_pct) begin
            return $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end
        s = (r - push_pct) * 100 / (100 - push_pct);
        if (s < 30) begin
            return FN_SEARCH;
        end else if (s < 75) begin
            return FN_REMOVE;
        end else if (s < 95) begin
            return $urandom_range(1) ? FN_DUMP_FWD : FN_DUMP_BWD;
        end
        return $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
    endfunction

    initial begin
        int idle_by_phase[3];
        idle_by_phase   = '{34, 83, 0};
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FN_PUSH_FRONT;
        i_value         = '0;
        sender_idle_pct = 34;
        grow_list       = 1'b1;
        foreach (value_pool[i]) begin
            value_pool[i] = $urandom;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases
        issue_command(FN_DUMP_FWD, '0);
        issue_command(FN_DUMP_BWD, '0);
        issue_command(FN_REMOVE, 32'sd5);
        // extremes, then fill to capacity
        issue_command(FN_PUSH_FRONT, 32'sh7fff_ffff);
        issue_command(FN_PUSH_BACK, 32'sh8000_0000);
        issue_command(FN_PUSH_FRONT, '1);
        issue_command(FN_PUSH_BACK, '0);
        for (int k = 4; k < LIST_DEPTH; k++) begin
            issue_command((k % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, $urandom);
        end
        issue_command(FN_PUSH_FRONT, 32'sd1);
        issue_command(FN_PUSH_BACK, 32'sd2);
        issue_command(FN_DUMP_FWD, '0);
        issue_command(FN_DUMP_BWD, '0);
        issue_command(FN_SEARCH, 32'sh8000_0000);
        issue_command(FN_REMOVE, 32'sh8000_0000);
        issue_command(FN_SPARE_A, '1);
        issue_command(FN_SPARE_B, '1);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = idle_by_phase[phase];
            for (int n = 0; n < PHASE_CMDS; n++) begin
                if (n % 30 == 0) begin
                    grow_list = ~grow_list;
                end
                if ($urandom_range(19) == 0) begin
                    value_pool[$urandom_range(7)] = $urandom;
                end
                if ($urandom_range(39) == 0) begin
                    drain_results();
                end
                issue_command(pick_code(), pick_value());
            end
            drain_results();
        end

        start <= 1'b0;
        for (int w = 0; w < 4000 && beats_pending != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && beats_pending == 0) begin
            $display("bounded_value_list_engine_unit verification clean");
        end else begin
            if (beats_pending != 0) begin
                $display("%0d expected result beats never arrived", beats_pending);
            end
            $display("bounded_value_list_engine_unit verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bvle_pkg.sv
hdl/bvle_dp.sv
hdl/bvle_ctrl.sv
hdl/bounded_value_list_engine_unit.sv
dv/bvle_list_checker.sv
dv/bounded_value_list_engine_unit_test.sv
